// ===== rtl/pnn_pkg.sv =====
// Shared constants and helper functions for the Newell polygon normal block.
// No dependencies.
package pnn_pkg;

	localparam int COORD_WIDTH      = 16;
	localparam int COORD_FRAC_BITS  = 8;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int COUNT_WIDTH      = 12;
	localparam int SUM_WIDTH        = 48;
	localparam int OUT_WIDTH        = 16;
	localparam int THR_WIDTH        = 16;
	localparam int MUL_WIDTH        = 24;
	localparam int SQ_WIDTH         = 2 * SUM_WIDTH;
	localparam int ROOT_WIDTH       = SUM_WIDTH;
	localparam int QUO_WIDTH        = NORMAL_FRAC_BITS + 2;
	localparam int RESCALE_SHIFT    = 2 * COORD_FRAC_BITS - NORMAL_FRAC_BITS;
	localparam logic [SUM_WIDTH:0] OUT_LIMIT = (SUM_WIDTH + 1)'(1) << NORMAL_FRAC_BITS;

	typedef logic signed [SUM_WIDTH-1:0] sum_t;
	typedef logic signed [OUT_WIDTH-1:0] comp_t;

	function automatic logic [SUM_WIDTH-1:0] sum_mag(input sum_t v);
		sum_mag = v[SUM_WIDTH-1] ? SUM_WIDTH'(-v) : SUM_WIDTH'(v);
	endfunction

	function automatic comp_t pack_comp(input logic neg, input logic [SUM_WIDTH:0] m);
		logic [SUM_WIDTH:0] c;
		c = (m > OUT_LIMIT) ? OUT_LIMIT : m;
		pack_comp = neg ? comp_t'(-c[OUT_WIDTH-1:0]) : comp_t'(c[OUT_WIDTH-1:0]);
	endfunction

	function automatic comp_t rescale(input sum_t v);
		logic [SUM_WIDTH:0] m;
		m = ({1'b0, sum_mag(v)} + (SUM_WIDTH + 1)'(1 << (RESCALE_SHIFT - 1))) >> RESCALE_SHIFT;
		rescale = pack_comp(v[SUM_WIDTH-1], m);
	endfunction

endpackage

// ===== rtl/polygon_normal_newell.sv =====
// Top level of the Newell polygon normal block: accumulation, square root, divides.
// Depends on pnn_pkg.
// A middle vertex is accepted, then its edge runs per component on the shared 24x24 multiplier.
// The last vertex adds its edge, the closing edge, squares (3 components x 4 parts), the root
// (one bit of 48 per step) and three 16-bit quotients, or a rescale for a degenerate face.
// A face under three vertices gives no result. Input waits only until the result is loaded.
// Reset clears all face state and sets the threshold to 7; no item is pending after reset.
module polygon_normal_newell (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [15:0] vertex_x,
	input  logic signed [15:0] vertex_y,
	input  logic signed [15:0] vertex_z,
	input  logic last_vertex,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic degenerate,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data
);
	import pnn_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_EDGE, S_SQ, S_ROOT, S_DIV, S_WAIT} state_t;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	state_t state_q;
	logic [THR_WIDTH-1:0] thr_q;
	logic signed [COORD_WIDTH-1:0] first_q [3];
	logic signed [COORD_WIDTH-1:0] prev_q [3];
	logic signed [COORD_WIDTH-1:0] cur_q [3];
	sum_t sum_q [3];
	logic [COUNT_WIDTH-1:0] count_q;
	logic last_q, closing_q;
	logic [1:0] comp_q, part_q;
	logic [SQ_WIDTH-1:0] sq_q;
	logic [ROOT_WIDTH+1:0] rem_root_q;
	logic [ROOT_WIDTH-1:0] root_q;
	logic [5:0] step_q;
	logic [SUM_WIDTH-1:0] drem_q;
	logic [QUO_WIDTH-1:0] quo_q;
	comp_t res_q [3];
	logic degen_q;

	logic signed [COORD_WIDTH-1:0] ea [3];
	logic signed [COORD_WIDTH-1:0] eb [3];
	logic signed [COORD_WIDTH:0] d, s;
	logic [COORD_WIDTH:0] dmag, smag;
	logic [MUL_WIDTH-1:0] mul_a, mul_b;
	logic [2*MUL_WIDTH-1:0] prod;
	logic signed [SUM_WIDTH:0] term, acc;
	sum_t acc_sat;
	logic [SUM_WIDTH-1:0] smag_sum;
	logic [SQ_WIDTH-1:0] sq_add;
	logic [ROOT_WIDTH+3:0] rt_rem, rt_trial;
	logic [SUM_WIDTH:0] dv_t, dv_r;
	logic dv_ge;
	logic [QUO_WIDTH-1:0] dv_q;
	logic [QUO_WIDTH:0] dv_round;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ea[i] = closing_q ? cur_q[i] : prev_q[i];
			eb[i] = closing_q ? first_q[i] : cur_q[i];
		end
		unique case (comp_q)
			2'd0: begin
				d = (COORD_WIDTH + 1)'(ea[1]) - (COORD_WIDTH + 1)'(eb[1]);
				s = (COORD_WIDTH + 1)'(ea[2]) + (COORD_WIDTH + 1)'(eb[2]);
			end
			2'd1: begin
				d = (COORD_WIDTH + 1)'(ea[2]) - (COORD_WIDTH + 1)'(eb[2]);
				s = (COORD_WIDTH + 1)'(ea[0]) + (COORD_WIDTH + 1)'(eb[0]);
			end
			default: begin
				d = (COORD_WIDTH + 1)'(ea[0]) - (COORD_WIDTH + 1)'(eb[0]);
				s = (COORD_WIDTH + 1)'(ea[1]) + (COORD_WIDTH + 1)'(eb[1]);
			end
		endcase
		dmag = d[COORD_WIDTH] ? (COORD_WIDTH + 1)'(-d) : (COORD_WIDTH + 1)'(d);
		smag = s[COORD_WIDTH] ? (COORD_WIDTH + 1)'(-s) : (COORD_WIDTH + 1)'(s);
		smag_sum = sum_mag(sum_q[comp_q]);

		if (state_q == S_SQ) begin
			mul_a = part_q[1] ? smag_sum[SUM_WIDTH-1:MUL_WIDTH] : smag_sum[MUL_WIDTH-1:0];
			mul_b = part_q[0] ? smag_sum[SUM_WIDTH-1:MUL_WIDTH] : smag_sum[MUL_WIDTH-1:0];
		end else begin
			mul_a = MUL_WIDTH'(dmag);
			mul_b = MUL_WIDTH'(smag);
		end
		prod = mul_a * mul_b;

		term = (d[COORD_WIDTH] ^ s[COORD_WIDTH]) ? -(SUM_WIDTH + 1)'(prod)
			: (SUM_WIDTH + 1)'(prod);
		acc = (SUM_WIDTH + 1)'(sum_q[comp_q]) + term;
		if (acc[SUM_WIDTH] != acc[SUM_WIDTH-1])
			acc_sat = acc[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
				: {1'b0, {(SUM_WIDTH-1){1'b1}}};
		else
			acc_sat = acc[SUM_WIDTH-1:0];

		unique case (part_q)
			2'd0:    sq_add = SQ_WIDTH'(prod);
			2'd3:    sq_add = SQ_WIDTH'(prod) << (2 * MUL_WIDTH);
			default: sq_add = SQ_WIDTH'(prod) << MUL_WIDTH;
		endcase

		rt_rem   = {rem_root_q, sq_q[SQ_WIDTH-1:SQ_WIDTH-2]};
		rt_trial = {2'b00, root_q, 2'b01};

		dv_t  = (step_q == '0) ? {1'b0, smag_sum} : {drem_q, 1'b0};
		dv_ge = (dv_t >= {1'b0, root_q});
		dv_r  = dv_ge ? dv_t - {1'b0, root_q} : dv_t;
		dv_q  = {quo_q[QUO_WIDTH-2:0], dv_ge};
		dv_round = ((QUO_WIDTH + 1)'(dv_q) + (QUO_WIDTH + 1)'(1)) >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			thr_q <= THR_WIDTH'(7);
			for (int i = 0; i < 3; i++) begin
				first_q[i] <= '0;
				prev_q[i] <= '0;
				cur_q[i] <= '0;
				sum_q[i] <= '0;
				res_q[i] <= '0;
			end
			count_q <= '0;
			last_q <= 1'b0;
			closing_q <= 1'b0;
			comp_q <= '0;
			part_q <= '0;
			sq_q <= '0;
			rem_root_q <= '0;
			root_q <= '0;
			step_q <= '0;
			drem_q <= '0;
			quo_q <= '0;
			degen_q <= 1'b0;
			out_valid <= 1'b0;
			normal_x <= '0;
			normal_y <= '0;
			normal_z <= '0;
			degenerate <= 1'b0;
		end else begin
			if (cfg_valid)
				thr_q <= cfg_data;
			if (out_valid && out_ready && state_q != S_WAIT)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cur_q[0] <= vertex_x;
						cur_q[1] <= vertex_y;
						cur_q[2] <= vertex_z;
						last_q <= last_vertex;
						comp_q <= '0;
						if (count_q != COUNT_MAX)
							count_q <= count_q + 1'b1;
						if (count_q == '0) begin
							first_q[0] <= vertex_x;
							first_q[1] <= vertex_y;
							first_q[2] <= vertex_z;
							prev_q[0] <= vertex_x;
							prev_q[1] <= vertex_y;
							prev_q[2] <= vertex_z;
							closing_q <= 1'b1;
							if (last_vertex)
								state_q <= S_EDGE;
						end else begin
							closing_q <= 1'b0;
							state_q <= S_EDGE;
						end
					end
				end
				S_EDGE: begin
					if (comp_q != 2'd2) begin
						sum_q[comp_q] <= acc_sat;
						comp_q <= comp_q + 1'b1;
					end else begin
						comp_q <= '0;
						if (!closing_q) begin
							sum_q[2] <= acc_sat;
							prev_q <= cur_q;
							closing_q <= 1'b1;
							state_q <= last_q ? S_EDGE : S_IDLE;
						end else if (count_q >= COUNT_WIDTH'(3)) begin
							sum_q[2] <= acc_sat;
							part_q <= '0;
							sq_q <= '0;
							state_q <= S_SQ;
						end else begin
							for (int i = 0; i < 3; i++)
								sum_q[i] <= '0;
							count_q <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_SQ: begin
					sq_q <= sq_q + sq_add;
					part_q <= part_q + 1'b1;
					if (part_q == 2'd3) begin
						if (comp_q != 2'd2) begin
							comp_q <= comp_q + 1'b1;
						end else begin
							comp_q <= '0;
							rem_root_q <= '0;
							root_q <= '0;
							step_q <= '0;
							state_q <= S_ROOT;
						end
					end
				end
				S_ROOT: begin
					sq_q <= sq_q << 2;
					if (rt_rem >= rt_trial) begin
						rem_root_q <= (ROOT_WIDTH + 2)'(rt_rem - rt_trial);
						root_q <= {root_q[ROOT_WIDTH-2:0], 1'b1};
					end else begin
						rem_root_q <= (ROOT_WIDTH + 2)'(rt_rem);
						root_q <= {root_q[ROOT_WIDTH-2:0], 1'b0};
					end
					if (step_q == 6'(ROOT_WIDTH - 1)) begin
						step_q <= '0;
						state_q <= S_DIV;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DIV: begin
					if (root_q <= SUM_WIDTH'(thr_q)) begin
						for (int i = 0; i < 3; i++)
							res_q[i] <= rescale(sum_q[i]);
						degen_q <= 1'b1;
						state_q <= S_WAIT;
					end else begin
						drem_q <= dv_r[SUM_WIDTH-1:0];
						quo_q <= dv_q;
						if (step_q == 6'(QUO_WIDTH - 1)) begin
							res_q[comp_q] <= pack_comp(sum_q[comp_q][SUM_WIDTH-1],
								(SUM_WIDTH + 1)'(dv_round));
							step_q <= '0;
							degen_q <= 1'b0;
							if (comp_q != 2'd2)
								comp_q <= comp_q + 1'b1;
							else begin
								comp_q <= '0;
								state_q <= S_WAIT;
							end
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				S_WAIT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						normal_x <= res_q[0];
						normal_y <= res_q[1];
						normal_z <= res_q[2];
						degenerate <= degen_q;
						for (int i = 0; i < 3; i++)
							sum_q[i] <= '0;
						count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
